// ===== hw/rtl/tllc_pkg.sv =====
// ----------------------------------------------------------------------------
// tllc_pkg
// Shared codes, register indexes and control types of the two-level cache.
// ----------------------------------------------------------------------------
package tllc_pkg;

    localparam logic [1:0] ACT_GET  = 2'd0;
    localparam logic [1:0] ACT_PUT  = 2'd1;
    localparam logic [1:0] ACT_WARM = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [1:0] LVL_MISS = 2'd0;
    localparam logic [1:0] LVL_L1   = 2'd1;
    localparam logic [1:0] LVL_L2   = 2'd2;
    localparam logic [1:0] PUT_NEW  = 2'd0;
    localparam logic [1:0] PUT_UPD  = 2'd1;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;
    localparam int L1_CAP_BITS   = 5;
    localparam int L2_CAP_BITS   = 7;
    localparam int THR_BITS      = 8;
    localparam int CNT_BITS      = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_L1_CAP  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_L2_CAP  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOT_THR = 2'd2;

    localparam logic [L1_CAP_BITS-1:0] L1_CAP_RST  = 5'd16;
    localparam logic [L2_CAP_BITS-1:0] L2_CAP_RST  = 7'd64;
    localparam logic [THR_BITS-1:0]    HOT_THR_RST = 8'd3;
    localparam logic [CNT_BITS-1:0]    CNT_MAX     = 8'hFF;

    typedef struct packed {
        logic get;
        logic put;
        logic warm;
    } t_kind;

    typedef struct packed {
        logic touch;
        logic insert;
    } t_store_cmd;

    typedef struct packed {
        logic hit;
        logic evict;
    } t_store_stat;

endpackage

// ===== hw/rtl/tllc_req_if.sv =====
// ----------------------------------------------------------------------------
// tllc_req_if
// Request channel: action, key and value with valid/ready.
// ----------------------------------------------------------------------------
interface tllc_req_if #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, action, key, value, input ready);
    modport sink   (input valid, action, key, value, output ready);
endinterface

// ===== hw/rtl/tllc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tllc_rsp_if
// Response channel: hit level, read value and event flags with valid/ready.
// ----------------------------------------------------------------------------
interface tllc_rsp_if #(
    parameter int VALUE_BITS = 64
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            hit_level;
    logic [VALUE_BITS-1:0] read_value;
    logic                  promoted;
    logic                  evicted;

    modport source (output valid, hit_level, read_value, promoted, evicted, input ready);
    modport sink   (input valid, hit_level, read_value, promoted, evicted, output ready);
endinterface

// ===== hw/rtl/tllc_front.sv =====
// ----------------------------------------------------------------------------
// tllc_front
// Accepts request items, decodes the action and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module tllc_front #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tllc_req_if.sink              s_req,
    output logic                  o_item_valid,
    output tllc_pkg::t_kind       o_kind,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value,
    input  logic                  i_item_pop
);
    tllc_pkg::t_kind       r_kind  [2];
    logic [KEY_BITS-1:0]   r_key   [2];
    logic [VALUE_BITS-1:0] r_value [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;
    tllc_pkg::t_kind       w_kind;
    logic                  w_push;

    always_comb begin
        w_kind = '0;
        unique case (s_req.action)
            tllc_pkg::ACT_GET:  w_kind.get  = 1'b1;
            tllc_pkg::ACT_PUT:  w_kind.put  = 1'b1;
            tllc_pkg::ACT_WARM: w_kind.warm = 1'b1;
            default:            w_kind = '0;
        endcase
    end

    assign s_req.ready  = (r_cnt != 2'd2);
    assign w_push       = s_req.valid && s_req.ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_kind       = r_kind[r_rp];
    assign o_key        = r_key[r_rp];
    assign o_value      = r_value[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_item_pop) r_rp <= ~r_rp;
            if (w_push && !i_item_pop) r_cnt <= r_cnt + 2'd1;
            else if (!w_push && i_item_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_kind[r_wp]  <= w_kind;
            r_key[r_wp]   <= s_req.key;
            r_value[r_wp] <= s_req.value;
        end
    end
endmodule

// ===== hw/rtl/tllc_store.sv =====
// ----------------------------------------------------------------------------
// tllc_store
// Fully associative key tags with valid bits, LRU ages and a fill count.
// ----------------------------------------------------------------------------
module tllc_store #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 64,
    parameter int CAP_BITS = 5,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [CAP_BITS-1:0]     i_cap,
    input  tllc_pkg::t_store_cmd    i_cmd,
    output tllc_pkg::t_store_stat   o_stat,
    output logic [IW-1:0]           o_hit_idx,
    output logic [IW-1:0]           o_slot
);
    logic [DEPTH-1:0]    r_valid;
    logic [KEY_BITS-1:0] r_keys [DEPTH];
    logic [IW-1:0]       r_age  [DEPTH];
    logic [CW-1:0]       r_used;

    logic [DEPTH-1:0] w_hit, w_old, w_free;
    logic [IW-1:0]    w_hit_age, w_top_age;
    logic [CW-1:0]    w_cap;
    logic             w_full;

    always_comb begin
        if (i_cap == '0) w_cap = CW'(1);
        else if (int'(i_cap) > DEPTH) w_cap = CW'(DEPTH);
        else w_cap = CW'(i_cap);
        w_full    = (r_used >= w_cap) && (r_used != '0);
        w_top_age = IW'(r_used - CW'(1));
        w_hit_age = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_hit[i] = r_valid[i] && (r_keys[i] == i_key);
            w_old[i] = r_valid[i] && (r_age[i] == w_top_age);
            if (w_hit[i]) w_hit_age = w_hit_age | r_age[i];
        end
        w_free    = ~r_valid | (w_full ? w_old : '0);
        o_hit_idx = '0;
        o_slot    = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_hit[i]) o_hit_idx = IW'(i);
            if (w_free[i]) o_slot = IW'(i);
        end
        o_stat.hit   = |w_hit;
        o_stat.evict = w_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
        end else if (i_cmd.insert) begin
            if (!w_full) r_used <= r_used + CW'(1);
            for (int i = 0; i < DEPTH; i++) begin
                if (IW'(i) == o_slot) r_valid[i] <= 1'b1;
                else if (w_full && w_old[i]) r_valid[i] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_cmd.touch) begin
                if (w_hit[i]) r_age[i] <= '0;
                else if (r_valid[i] && r_age[i] < w_hit_age) r_age[i] <= r_age[i] + IW'(1);
            end else if (i_cmd.insert) begin
                if (IW'(i) == o_slot) begin
                    r_age[i]  <= '0;
                    r_keys[i] <= i_key;
                end else if (r_valid[i] && !(w_full && w_old[i])) begin
                    r_age[i] <= r_age[i] + IW'(1);
                end
            end
        end
    end
endmodule

// ===== hw/rtl/tllc_back.sv =====
// ----------------------------------------------------------------------------
// tllc_back
// Executes queued items against L1 and L2 and registers one result per item.
// ----------------------------------------------------------------------------
module tllc_back #(
    parameter int L1_DEPTH   = 16,
    parameter int L2_DEPTH   = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64,
    localparam int I1 = (L1_DEPTH > 1) ? $clog2(L1_DEPTH) : 1,
    localparam int I2 = (L2_DEPTH > 1) ? $clog2(L2_DEPTH) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_item_valid,
    input  tllc_pkg::t_kind                    i_kind,
    input  logic [KEY_BITS-1:0]                i_key,
    input  logic [VALUE_BITS-1:0]              i_value,
    output logic                               o_item_pop,
    input  logic [tllc_pkg::L1_CAP_BITS-1:0]   i_l1_cap,
    input  logic [tllc_pkg::L2_CAP_BITS-1:0]   i_l2_cap,
    input  logic [tllc_pkg::THR_BITS-1:0]      i_hot_thr,
    tllc_rsp_if.source                         m_rsp
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;

    logic [1:0]            r_state, n_state;
    tllc_pkg::t_kind       r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [I2-1:0]         r_l2_idx;

    logic                  r_ov;
    logic [1:0]            r_level;
    logic [VALUE_BITS-1:0] r_rd;
    logic                  r_promoted, r_evicted;

    logic [VALUE_BITS-1:0]         r_l1_val [L1_DEPTH];
    logic [VALUE_BITS-1:0]         r_l2_mem [L2_DEPTH];
    logic [tllc_pkg::CNT_BITS-1:0] r_cnt_mem [L2_DEPTH];
    logic [VALUE_BITS-1:0]         r_l2_rd;
    logic [tllc_pkg::CNT_BITS-1:0] r_cnt_rd;

    tllc_pkg::t_store_cmd  w_c1, w_c2;
    tllc_pkg::t_store_stat w_s1, w_s2;
    logic [I1-1:0]         w_h1, w_slot1;
    logic [I2-1:0]         w_h2, w_slot2;

    logic                          w_done;
    logic [1:0]                    w_level;
    logic [VALUE_BITS-1:0]         w_rd;
    logic                          w_promoted, w_evicted;
    logic                          w_l1_we;
    logic [I1-1:0]                 w_l1_addr;
    logic [VALUE_BITS-1:0]         w_l1_data;
    logic                          w_l2_we, w_cnt_we;
    logic [I2-1:0]                 w_l2_addr, w_cnt_addr;
    logic [tllc_pkg::CNT_BITS-1:0] w_cnt_data, w_cnt_new;

    tllc_store #(.DEPTH(L1_DEPTH), .KEY_BITS(KEY_BITS), .CAP_BITS(tllc_pkg::L1_CAP_BITS)) u_l1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key(r_key), .i_cap(i_l1_cap),
        .i_cmd(w_c1), .o_stat(w_s1), .o_hit_idx(w_h1), .o_slot(w_slot1)
    );

    tllc_store #(.DEPTH(L2_DEPTH), .KEY_BITS(KEY_BITS), .CAP_BITS(tllc_pkg::L2_CAP_BITS)) u_l2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key(r_key), .i_cap(i_l2_cap),
        .i_cmd(w_c2), .o_stat(w_s2), .o_hit_idx(w_h2), .o_slot(w_slot2)
    );

    assign o_item_pop = (r_state == S_IDLE) && i_item_valid && !r_ov;
    assign w_cnt_new  = (r_cnt_rd == tllc_pkg::CNT_MAX) ? r_cnt_rd
                                                         : r_cnt_rd + tllc_pkg::CNT_BITS'(1);

    always_comb begin
        n_state    = r_state;
        w_c1       = '0;
        w_c2       = '0;
        w_done     = 1'b0;
        w_level    = tllc_pkg::LVL_MISS;
        w_rd       = '0;
        w_promoted = 1'b0;
        w_evicted  = 1'b0;
        w_l1_we    = 1'b0;
        w_l1_addr  = w_slot1;
        w_l1_data  = r_value;
        w_l2_we    = 1'b0;
        w_l2_addr  = w_slot2;
        w_cnt_we   = 1'b0;
        w_cnt_addr = w_slot2;
        w_cnt_data = '0;
        unique case (r_state)
            S_IDLE: begin
                if (o_item_pop) n_state = S_LOOK;
            end
            S_LOOK: begin
                w_done  = 1'b1;
                n_state = S_IDLE;
                if (r_kind.get) begin
                    if (w_s1.hit) begin
                        w_c1.touch = 1'b1;
                        w_level    = tllc_pkg::LVL_L1;
                        w_rd       = r_l1_val[w_h1];
                    end else if (w_s2.hit) begin
                        w_c2.touch = 1'b1;
                        w_done     = 1'b0;
                        n_state    = S_RD;
                    end
                end else if (r_kind.put) begin
                    w_l2_we = 1'b1;
                    if (w_s2.hit) begin
                        w_c2.touch = 1'b1;
                        w_l2_addr  = w_h2;
                        w_level    = tllc_pkg::PUT_UPD;
                    end else begin
                        w_c2.insert = 1'b1;
                        w_cnt_we    = 1'b1;
                        w_evicted   = w_s2.evict;
                        w_level     = tllc_pkg::PUT_NEW;
                    end
                end else if (r_kind.warm) begin
                    w_l1_we = 1'b1;
                    if (w_s1.hit) begin
                        w_c1.touch = 1'b1;
                        w_l1_addr  = w_h1;
                        w_level    = tllc_pkg::PUT_UPD;
                    end else begin
                        w_c1.insert = 1'b1;
                        w_evicted   = w_s1.evict;
                        w_level     = tllc_pkg::PUT_NEW;
                    end
                end
            end
            S_RD: begin
                w_done     = 1'b1;
                n_state    = S_IDLE;
                w_level    = tllc_pkg::LVL_L2;
                w_rd       = r_l2_rd;
                w_cnt_we   = 1'b1;
                w_cnt_addr = r_l2_idx;
                w_cnt_data = w_cnt_new;
                if (w_cnt_new >= i_hot_thr) begin
                    w_c1.insert = 1'b1;
                    w_l1_we     = 1'b1;
                    w_l1_data   = r_l2_rd;
                    w_promoted  = 1'b1;
                    w_evicted   = w_s1.evict;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) r_ov <= 1'b1;
            else if (m_rsp.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (r_state == S_LOOK) r_l2_idx <= w_h2;
        if (w_done) begin
            r_level    <= w_level;
            r_rd       <= w_rd;
            r_promoted <= w_promoted;
            r_evicted  <= w_evicted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_l1_we) r_l1_val[w_l1_addr] <= w_l1_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_l2_we) r_l2_mem[w_l2_addr] <= r_value;
        r_l2_rd <= r_l2_mem[w_h2];
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) r_cnt_mem[w_cnt_addr] <= w_cnt_data;
        r_cnt_rd <= r_cnt_mem[w_h2];
    end

    assign m_rsp.valid      = r_ov;
    assign m_rsp.hit_level  = r_level;
    assign m_rsp.read_value = r_rd;
    assign m_rsp.promoted   = r_promoted;
    assign m_rsp.evicted    = r_evicted;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_pop |-> (r_state == S_IDLE && !r_ov))
        else $error("item taken while busy");

    a_prom_l2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_promoted) |-> (r_level == tllc_pkg::LVL_L2))
        else $error("promotion without L2 hit");

    a_rd_from_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ($past(r_state) == S_LOOK))
        else $error("read state entered out of order");

    a_rd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_ov && r_state == S_IDLE))
        else $error("read state did not complete");
endmodule

// ===== hw/rtl/two_level_lru_cache_with_promotion_core.sv =====
// ----------------------------------------------------------------------------
// two_level_lru_cache_with_promotion_core
// Two-level LRU key/value cache with count-based promotion from L2 to L1.
// ----------------------------------------------------------------------------
// Use: requests enter on s_req (valid/ready; action, key, value), results leave
// on m_rsp (valid/ready; hit_level, read_value, promoted, evicted), one result
// per request, in order. A two-deep request queue decouples the input from the
// execution engine, so requests are taken while a result waits on m_rsp.
// Each request passes through the engine in order: dequeue, parallel tag search
// with LRU update, result. A get that hits only in L2 also passes a read state
// for the registered read of the L2 value and count memories and the promotion.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) is to be written by the user
// only while idle; the block itself does not enforce this.
// Reset: all entries invalid, capacities 16 and 64, hot threshold 3; no
// clearing pass. When m_rsp stalls the held result blocks the engine and the
// queue fills, then s_req.ready drops.
// ----------------------------------------------------------------------------
module two_level_lru_cache_with_promotion_core #(
    parameter int L1_DEPTH   = 16,
    parameter int L2_DEPTH   = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tllc_req_if.sink                            s_req,
    tllc_rsp_if.source                          m_rsp,
    input  logic                                i_cfg_we,
    input  logic [tllc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [tllc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    logic [tllc_pkg::L1_CAP_BITS-1:0] r_l1_cap;
    logic [tllc_pkg::L2_CAP_BITS-1:0] r_l2_cap;
    logic [tllc_pkg::THR_BITS-1:0]    r_hot_thr;

    logic                  w_item_valid, w_item_pop;
    tllc_pkg::t_kind       w_kind;
    logic [KEY_BITS-1:0]   w_key;
    logic [VALUE_BITS-1:0] w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_cap  <= tllc_pkg::L1_CAP_RST;
            r_l2_cap  <= tllc_pkg::L2_CAP_RST;
            r_hot_thr <= tllc_pkg::HOT_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tllc_pkg::CFG_L1_CAP:  r_l1_cap  <= i_cfg_data[tllc_pkg::L1_CAP_BITS-1:0];
                tllc_pkg::CFG_L2_CAP:  r_l2_cap  <= i_cfg_data[tllc_pkg::L2_CAP_BITS-1:0];
                tllc_pkg::CFG_HOT_THR: r_hot_thr <= i_cfg_data[tllc_pkg::THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    tllc_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_req(s_req),
        .o_item_valid(w_item_valid), .o_kind(w_kind), .o_key(w_key),
        .o_value(w_value), .i_item_pop(w_item_pop)
    );

    tllc_back #(
        .L1_DEPTH(L1_DEPTH), .L2_DEPTH(L2_DEPTH),
        .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item_valid(w_item_valid), .i_kind(w_kind), .i_key(w_key),
        .i_value(w_value), .o_item_pop(w_item_pop),
        .i_l1_cap(r_l1_cap), .i_l2_cap(r_l2_cap), .i_hot_thr(r_hot_thr),
        .m_rsp(m_rsp)
    );
endmodule

// ===== sim/two_level_lru_cache_with_promotion_core_test.sv =====
// ----------------------------------------------------------------------------
// two_level_lru_cache_with_promotion_core_test
// Self-checking bench: a clocked driver feeds requests from a backlog, a
// shadow of both LRU stores predicts every response, and a clocked monitor
// compares each response field by field. Runs directed cases, then random
// traffic under several capacity and threshold settings, with random stalls.
// ----------------------------------------------------------------------------
module two_level_lru_cache_with_promotion_core_test;

    localparam int L1N = 16;
    localparam int L2N = 64;
    localparam int WD_LIMIT = 5000;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key;
        logic [63:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]  hit_level;
        logic [63:0] read_value;
        logic        promoted;
        logic        evicted;
    } t_rsp;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [tllc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [tllc_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;

    tllc_req_if #(.KEY_BITS(64), .VALUE_BITS(64)) req();
    tllc_rsp_if #(.VALUE_BITS(64)) rsp();

    two_level_lru_cache_with_promotion_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_req(req.sink), .m_rsp(rsp.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // shadow state
    bit          l1_v[L1N];
    logic [63:0] l1_k[L1N];
    logic [63:0] l1_d[L1N];
    int          l1_a[L1N];
    bit          l2_v[L2N];
    logic [63:0] l2_k[L2N];
    logic [63:0] l2_d[L2N];
    int          l2_a[L2N];
    int          l2_c[L2N];
    int          l1_cap = tllc_pkg::L1_CAP_RST;
    int          l2_cap = tllc_pkg::L2_CAP_RST;
    int          hot_thr = tllc_pkg::HOT_THR_RST;

    t_req  req_backlog[$];
    t_rsp  pending_rsp[$];
    logic [63:0] key_pool[96];
    bit    calm = 0;
    bit    failed = 0;
    int    quiet_cycles = 0;

    function automatic int clamp(int cap, int depth);
        if (cap == 0) return 1;
        if (cap > depth) return depth;
        return cap;
    endfunction

    function automatic bit l1_store(logic [63:0] key, logic [63:0] val, ref bit ev);
        int hit, used, old, slot, a;
        hit = -1; used = 0; old = -1; slot = 0;
        for (int i = 0; i < L1N; i++) if (l1_v[i] && l1_k[i] == key && hit < 0) hit = i;
        if (hit >= 0) begin
            l1_d[hit] = val;
            a = l1_a[hit];
            for (int i = 0; i < L1N; i++) if (l1_v[i] && l1_a[i] < a) l1_a[i]++;
            l1_a[hit] = 0;
            return 1;
        end
        for (int i = 0; i < L1N; i++) if (l1_v[i]) used++;
        if (used >= clamp(l1_cap, L1N) && used > 0) begin
            for (int i = 0; i < L1N; i++)
                if (l1_v[i] && (old < 0 || l1_a[i] > l1_a[old])) old = i;
            l1_v[old] = 0;
            ev = 1;
        end
        for (int i = L1N - 1; i >= 0; i--) if (!l1_v[i]) slot = i;
        for (int i = 0; i < L1N; i++) if (l1_v[i]) l1_a[i]++;
        l1_v[slot] = 1; l1_k[slot] = key; l1_d[slot] = val; l1_a[slot] = 0;
        return 0;
    endfunction

    function automatic bit l2_store(logic [63:0] key, logic [63:0] val, ref bit ev);
        int hit, used, old, slot, a;
        hit = -1; used = 0; old = -1; slot = 0;
        for (int i = 0; i < L2N; i++) if (l2_v[i] && l2_k[i] == key && hit < 0) hit = i;
        if (hit >= 0) begin
            l2_d[hit] = val;
            a = l2_a[hit];
            for (int i = 0; i < L2N; i++) if (l2_v[i] && l2_a[i] < a) l2_a[i]++;
            l2_a[hit] = 0;
            return 1;
        end
        for (int i = 0; i < L2N; i++) if (l2_v[i]) used++;
        if (used >= clamp(l2_cap, L2N) && used > 0) begin
            for (int i = 0; i < L2N; i++)
                if (l2_v[i] && (old < 0 || l2_a[i] > l2_a[old])) old = i;
            l2_v[old] = 0;
            ev = 1;
        end
        for (int i = L2N - 1; i >= 0; i--) if (!l2_v[i]) slot = i;
        for (int i = 0; i < L2N; i++) if (l2_v[i]) l2_a[i]++;
        l2_v[slot] = 1; l2_k[slot] = key; l2_d[slot] = val; l2_a[slot] = 0; l2_c[slot] = 0;
        return 0;
    endfunction

    function automatic t_rsp cache_step(t_req r);
        t_rsp o;
        bit ev, dummy;
        int h, a;
        o = '0; ev = 0; h = -1;
        if (r.action == tllc_pkg::ACT_GET) begin
            for (int i = 0; i < L1N; i++) if (l1_v[i] && l1_k[i] == r.key && h < 0) h = i;
            if (h >= 0) begin
                a = l1_a[h];
                for (int i = 0; i < L1N; i++) if (l1_v[i] && l1_a[i] < a) l1_a[i]++;
                l1_a[h] = 0;
                o.hit_level = tllc_pkg::LVL_L1;
                o.read_value = l1_d[h];
            end else begin
                for (int i = 0; i < L2N; i++) if (l2_v[i] && l2_k[i] == r.key && h < 0) h = i;
                if (h >= 0) begin
                    a = l2_a[h];
                    for (int i = 0; i < L2N; i++) if (l2_v[i] && l2_a[i] < a) l2_a[i]++;
                    l2_a[h] = 0;
                    if (l2_c[h] < 255) l2_c[h]++;
                    o.hit_level = tllc_pkg::LVL_L2;
                    o.read_value = l2_d[h];
                    if (l2_c[h] >= hot_thr) begin
                        dummy = l1_store(r.key, l2_d[h], ev);
                        o.promoted = 1;
                    end
                end
            end
        end else if (r.action == tllc_pkg::ACT_PUT) begin
            o.hit_level = l2_store(r.key, r.value, ev) ? tllc_pkg::PUT_UPD : tllc_pkg::PUT_NEW;
        end else if (r.action == tllc_pkg::ACT_WARM) begin
            o.hit_level = l1_store(r.key, r.value, ev) ? tllc_pkg::PUT_UPD : tllc_pkg::PUT_NEW;
        end
        o.evicted = ev;
        return o;
    endfunction

    function automatic bit idle_roll();
        return !calm && ($urandom_range(99) < 12);
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_req nxt;
        if (!i_rst_n) begin
            req.valid <= 0;
            req.action <= '0;
            req.key <= '0;
            req.value <= '0;
        end else begin
            if (req.valid && req.ready) begin
                pending_rsp = {pending_rsp, cache_step({req.action, req.key, req.value})};
            end
            if (!req.valid || req.ready) begin
                if (req_backlog.size() > 0 && !idle_roll()) begin
                    nxt = req_backlog.pop_front();
                    req.valid <= 1;
                    req.action <= nxt.action;
                    req.key <= nxt.key;
                    req.value <= nxt.value;
                end else begin
                    req.valid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp got, exp_r;
        if (!i_rst_n) begin
            rsp.ready <= 0;
        end else begin
            rsp.ready <= !idle_roll();
            if (rsp.valid && rsp.ready) begin
                got = {rsp.hit_level, rsp.read_value, rsp.promoted, rsp.evicted};
                if (pending_rsp.size() == 0) begin
                    $display("%0t: unexpected item, actual %h", $time, got);
                    failed = 1;
                end else begin
                    exp_r = pending_rsp.pop_front();
                    if (got.hit_level !== exp_r.hit_level)
                        $display("%0t: hit_level expected %0d actual %0d", $time,
                                 exp_r.hit_level, got.hit_level);
                    if (got.read_value !== exp_r.read_value)
                        $display("%0t: read_value expected %h actual %h", $time,
                                 exp_r.read_value, got.read_value);
                    if (got.promoted !== exp_r.promoted)
                        $display("%0t: promoted expected %0d actual %0d", $time,
                                 exp_r.promoted, got.promoted);
                    if (got.evicted !== exp_r.evicted)
                        $display("%0t: evicted expected %0d actual %0d", $time,
                                 exp_r.evicted, got.evicted);
                    if (got !== exp_r) failed = 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_req(logic [1:0] act, logic [63:0] key, logic [63:0] val);
        t_req r;
        r.action = act; r.key = key; r.value = val;
        req_backlog = {req_backlog, r};
    endtask

    task automatic drain();
        while (req_backlog.size() > 0 || req.valid || pending_rsp.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [tllc_pkg::CFG_IDX_BITS-1:0] idx, logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == tllc_pkg::CFG_L1_CAP) l1_cap = data & 8'h1F;
        else if (idx == tllc_pkg::CFG_L2_CAP) l2_cap = data & 8'h7F;
        else if (idx == tllc_pkg::CFG_HOT_THR) hot_thr = data;
    endtask

    task automatic random_phase(int n, int span);
        int roll;
        logic [1:0] act;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            act = roll < 50 ? tllc_pkg::ACT_GET : roll < 78 ? tllc_pkg::ACT_PUT :
                  roll < 97 ? tllc_pkg::ACT_WARM : tllc_pkg::ACT_NONE;
            push_req(act, key_pool[$urandom_range(span - 1)], {$urandom, $urandom});
        end
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 96; i++) key_pool[i] = {$urandom, $urandom};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reset settings
        push_req(tllc_pkg::ACT_GET, 64'h0, 64'h0);
        push_req(tllc_pkg::ACT_PUT, 64'h0, '1);
        push_req(tllc_pkg::ACT_PUT, '1, 64'h0);
        push_req(tllc_pkg::ACT_GET, '1, '1);
        push_req(tllc_pkg::ACT_PUT, '1, 64'h5555_AAAA_5555_AAAA);
        push_req(tllc_pkg::ACT_GET, '1, 64'h0);
        push_req(tllc_pkg::ACT_GET, '1, 64'h0);
        push_req(tllc_pkg::ACT_GET, '1, 64'h0);
        push_req(tllc_pkg::ACT_PUT, '1, 64'hAAAA_5555_AAAA_5555);
        push_req(tllc_pkg::ACT_GET, '1, 64'h0);
        push_req(tllc_pkg::ACT_WARM, 64'h0, 64'h1234);
        push_req(tllc_pkg::ACT_WARM, 64'h0, 64'h5678);
        push_req(tllc_pkg::ACT_GET, 64'h0, 64'h0);
        push_req(tllc_pkg::ACT_NONE, '1, '1);
        drain();
        // tight capacities force evictions
        cfg_write(tllc_pkg::CFG_L1_CAP, 8'd1);
        cfg_write(tllc_pkg::CFG_L2_CAP, 8'd2);
        cfg_write(tllc_pkg::CFG_HOT_THR, 8'd1);
        push_req(tllc_pkg::ACT_PUT, key_pool[2], 64'h11);
        push_req(tllc_pkg::ACT_PUT, key_pool[3], 64'h22);
        push_req(tllc_pkg::ACT_PUT, key_pool[4], 64'h33);
        push_req(tllc_pkg::ACT_GET, key_pool[3], 64'h0);
        push_req(tllc_pkg::ACT_GET, key_pool[4], 64'h0);
        push_req(tllc_pkg::ACT_WARM, key_pool[5], 64'h44);
        push_req(tllc_pkg::ACT_GET, key_pool[2], 64'h0);
        drain();

        // random phases across settings
        cfg_write(tllc_pkg::CFG_L1_CAP, 8'd16); cfg_write(tllc_pkg::CFG_L2_CAP, 8'd64);
        cfg_write(tllc_pkg::CFG_HOT_THR, 8'd3);
        random_phase(250, 96);
        drain();
        cfg_write(tllc_pkg::CFG_L1_CAP, 8'd4); cfg_write(tllc_pkg::CFG_L2_CAP, 8'd8);
        cfg_write(tllc_pkg::CFG_HOT_THR, 8'd2);
        random_phase(200, 14);
        drain();
        cfg_write(tllc_pkg::CFG_L1_CAP, 8'd0); cfg_write(tllc_pkg::CFG_L2_CAP, 8'd0);
        cfg_write(tllc_pkg::CFG_HOT_THR, 8'd0);
        random_phase(120, 5);
        drain();
        calm = 1;
        cfg_write(tllc_pkg::CFG_L1_CAP, 8'd31); cfg_write(tllc_pkg::CFG_L2_CAP, 8'd127);
        cfg_write(tllc_pkg::CFG_HOT_THR, 8'd255);
        random_phase(200, 40);
        drain();
        calm = 0;
        cfg_write(tllc_pkg::CFG_L1_CAP, 8'd20); cfg_write(tllc_pkg::CFG_L2_CAP, 8'd100);
        cfg_write(tllc_pkg::CFG_HOT_THR, 8'd5);
        random_phase(250, 70);
        drain();
        cfg_write(tllc_pkg::CFG_L1_CAP, 8'd3); cfg_write(tllc_pkg::CFG_L2_CAP, 8'd12);
        cfg_write(tllc_pkg::CFG_HOT_THR, 8'd1);
        random_phase(260, 20);
        drain();
        repeat (20) @(posedge i_clk);

        if (!failed && pending_rsp.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
